FILE: rtl/kernel_convolution_3x3_core_macros.svh
// ----------------------------------------------------------------------------
// kernel_convolution_3x3_core_macros
// Assertion macros used by the checker of the 3x3 convolution core.
// ----------------------------------------------------------------------------
`ifndef KERNEL_CONVOLUTION_3X3_CORE_MACROS_SVH
`define KERNEL_CONVOLUTION_3X3_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KC3_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KC3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/kc3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kc3_pkg
// Types, constants and helpers of the 3x3 convolution core.
// ----------------------------------------------------------------------------
package kc3_pkg;

   localparam int KC3_MAX_WIDTH = 1024;

   localparam int PIXEL_W      = 8;
   localparam int COEF_W       = 16;
   localparam int ROW_W        = 48;
   localparam int FILT_W       = 28;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int ROW_CNT_W    = 12;
   localparam int MIN_DIM      = 3;
   localparam int MAX_HEIGHT   = 4096;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 48;

   localparam int PROD_W   = PIXEL_W + 1 + COEF_W;  // signed pixel times coefficient
   localparam int ROWSUM_W = PROD_W + 2;            // three products
   localparam int SUM_W    = PROD_W + 4;            // nine products

   localparam int FILT_LIMIT = 75202560;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [ROW_W-1:0]        COEF_TOP_RESET    = 48'h0000_0000_0000;
   localparam logic [ROW_W-1:0]        COEF_MIDDLE_RESET = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0]        COEF_BOTTOM_RESET = 48'h0000_0000_0000;

   typedef logic        [PIXEL_W-1:0]  pixel_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic        [ROW_W-1:0]    coef_row_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ROWSUM_W-1:0] rowsum_type;
   typedef logic signed [FILT_W-1:0]   filtered_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_IMAGE_HEIGHT    = 3'd1,
      CSR_COEF_ROW_TOP    = 3'd2,
      CSR_COEF_ROW_MIDDLE = 3'd3,
      CSR_COEF_ROW_BOTTOM = 3'd4
   } csr_index_type;

   // Column 0 is the left coefficient, in the upper bits of the row.
   function automatic coef_type coef_at(coef_row_type row, int col);
      return coef_type'(row[ROW_W-1-COEF_W*col -: COEF_W]);
   endfunction

endpackage

FILE: rtl/kc3_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kc3_req_if
// Pixel channel of the 3x3 convolution core.
// ----------------------------------------------------------------------------
interface kc3_req_if import kc3_pkg::*;;
   logic      valid;
   logic      ready;
   pixel_type pixel;
   logic      frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

FILE: rtl/kc3_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kc3_rsp_if
// Result channel of the 3x3 convolution core.
// ----------------------------------------------------------------------------
interface kc3_rsp_if import kc3_pkg::*;;
   logic         valid;
   logic         ready;
   filtered_type filtered;
   logic         frame_last;

   modport source (output valid, output filtered, output frame_last, input ready);
   modport sink   (input valid, input filtered, input frame_last, output ready);
endinterface

FILE: rtl/kc3_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kc3_csr_if
// Register write channel of the 3x3 convolution core.
// ----------------------------------------------------------------------------
interface kc3_csr_if import kc3_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/kernel_convolution_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_convolution_3x3_core
// 3x3 convolution over an 8-bit raster pixel stream with a programmable kernel.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while no stalled result backs the stages up,
// and returns one result for every interior pixel of the frame (first and
// last rows and columns give none). A result carries the exact kernel sum in
// units of 2^-14; the pixel that completes its window, i.e. the pixel below
// and to the right of the center, passes the line-store stage, the window,
// product and row-sum stages and then reaches the result register.
// The rate is set by the line store: one RAM, one row of MAX_WIDTH entries,
// that holds both previous rows side by side; it is read when a pixel is
// accepted and written back when that pixel leaves stage 1, with a forward
// path for a back-to-back pair at the same column. Every stage keeps its own
// valid bit, so a stalled result only blocks the stages that are full.
// The line store needs no clearing after reset.
// Write registers only while the core is idle; csr ready is always high.
// ----------------------------------------------------------------------------
module kernel_convolution_3x3_core import kc3_pkg::*; #(
   parameter int MAX_WIDTH = KC3_MAX_WIDTH
) (
   input logic        clock,
   input logic        reset,
   kc3_req_if.sink    req_if,
   kc3_rsp_if.source  rsp_if,
   kc3_csr_if.sink    csr_if
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
   localparam int LW = 2 * PIXEL_W;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   coef_row_type            coef_ff [3];

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         coef_ff[0] <= COEF_TOP_RESET;
         coef_ff[1] <= COEF_MIDDLE_RESET;
         coef_ff[2] <= COEF_BOTTOM_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_IMAGE_WIDTH:     width_ff   <= csr_if.data[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT:    height_ff  <= csr_if.data[HEIGHT_REG_W-1:0];
            CSR_COEF_ROW_TOP:    coef_ff[0] <= csr_if.data[ROW_W-1:0];
            CSR_COEF_ROW_MIDDLE: coef_ff[1] <= csr_if.data[ROW_W-1:0];
            CSR_COEF_ROW_BOTTOM: coef_ff[2] <= csr_if.data[ROW_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // Clamp geometry into the supported range.
   logic [WW-1:0]           width_ext;
   logic [WW-1:0]           w_eff;
   logic [HEIGHT_REG_W-1:0] h_eff;

   assign width_ext = WW'(width_ff);

   always_comb begin
      if (width_ext < WW'(MIN_DIM)) begin
         w_eff = WW'(MIN_DIM);
      end else if (width_ext > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = width_ext;
      end
      if (height_ff < HEIGHT_REG_W'(MIN_DIM)) begin
         h_eff = HEIGHT_REG_W'(MIN_DIM);
      end else if (height_ff > HEIGHT_REG_W'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage handshake: each stage takes a new item when empty or draining
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;
   logic s1_move, s2_move, s3_move, s4_move;
   logic accept;

   assign s5_ready = !rsp_valid_ff || rsp_if.ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   assign accept  = req_if.valid && s1_ready;
   assign s1_move = s1_valid_ff && s2_ready;
   assign s2_move = s2_valid_ff && s3_ready;
   assign s3_move = s3_valid_ff && s4_ready;
   assign s4_move = s4_valid_ff && s5_ready;

   assign req_if.ready = s1_ready;

   // ------------------------------------------------------------------
   // Raster position, computed as the pixel is accepted
   // ------------------------------------------------------------------
   logic [CW-1:0]        col_ff, col_in;
   logic [ROW_CNT_W-1:0] row_ff, row_in;
   logic [CW-1:0]        pos_col;
   logic [ROW_CNT_W-1:0] pos_row;
   logic [WW-1:0]        pos_col_ext;
   logic [HEIGHT_REG_W-1:0] pos_row_ext;
   logic                 col_wrap, row_wrap;
   logic                 pos_emit, pos_last;

   // A frame start restarts the position before this pixel is placed.
   assign pos_col     = req_if.frame_start ? '0 : col_ff;
   assign pos_row     = req_if.frame_start ? '0 : row_ff;
   assign pos_col_ext = WW'(pos_col);
   assign pos_row_ext = HEIGHT_REG_W'(pos_row);

   assign col_wrap = (pos_col_ext + WW'(1)) >= w_eff;
   assign row_wrap = (pos_row_ext + HEIGHT_REG_W'(1)) >= h_eff;
   assign pos_emit = (pos_row >= ROW_CNT_W'(2)) && (pos_col >= CW'(2));
   assign pos_last = (pos_row_ext == h_eff - HEIGHT_REG_W'(1))
                  && (pos_col_ext == w_eff - WW'(1));

   always_comb begin
      if (col_wrap) begin
         col_in = '0;
         row_in = row_wrap ? '0 : pos_row + ROW_CNT_W'(1);
      end else begin
         col_in = pos_col + CW'(1);
         row_in = pos_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: line store read lands, write back upon leaving
   // ------------------------------------------------------------------
   pixel_type     s1_pixel_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_emit_ff, s1_last_ff;
   logic          s1_byp_ff;
   logic [LW-1:0] s1_byp_data_ff;
   logic [LW-1:0] ram_rd_data;
   logic [LW-1:0] line_data;
   logic [LW-1:0] line_wr_data;
   pixel_type     line_upper, line_lower;

   // Each entry holds {row r-2, row r-1} for one column.
   assign line_data    = s1_byp_ff ? s1_byp_data_ff : ram_rd_data;
   assign line_upper   = line_data[LW-1:PIXEL_W];
   assign line_lower   = line_data[PIXEL_W-1:0];
   assign line_wr_data = {line_lower, s1_pixel_ff};

   kc3_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr_data),
      .rd_en   (accept),
      .rd_addr (pos_col),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Forward the write back when the next pixel reads the same column
   // in the same cycle (a frame start right after a pixel in column 0).
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= req_if.pixel;
         s1_col_ff      <= pos_col;
         s1_emit_ff     <= pos_emit;
         s1_last_ff     <= pos_last;
         s1_byp_ff      <= s1_move && (s1_col_ff == pos_col);
         s1_byp_data_ff <= line_wr_data;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: the 3x3 window, shifted once per pixel
   // ------------------------------------------------------------------
   pixel_type win_ff [3][3];
   logic      s2_emit_ff, s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (s1_move) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= line_upper;
         win_ff[1][2] <= line_lower;
         win_ff[2][2] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_move) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_move) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_emit_ff <= s1_emit_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: nine products; border pixels are dropped here
   // ------------------------------------------------------------------
   prod_type prod_ff [3][3];
   logic     s3_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s2_move) begin
         s3_valid_ff <= s2_emit_ff;
      end else if (s3_move) begin
         s3_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= $signed({1'b0, win_ff[i][j]}) * coef_at(coef_ff[i], j);
            end
         end
         s3_last_ff <= s2_last_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: one sum per kernel row
   // ------------------------------------------------------------------
   rowsum_type rowsum_ff [3];
   logic       s4_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s3_move) begin
         s4_valid_ff <= 1'b1;
      end else if (s4_move) begin
         s4_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_move) begin
         for (int i = 0; i < 3; i++) begin
            rowsum_ff[i] <= ROWSUM_W'(prod_ff[i][0]) + ROWSUM_W'(prod_ff[i][1])
                          + ROWSUM_W'(prod_ff[i][2]);
         end
         s4_last_ff <= s3_last_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: result register
   // ------------------------------------------------------------------
   logic signed [SUM_W-1:0] sum_in;
   filtered_type            filtered_ff;
   logic                    frame_last_ff;

   // The exact sum always fits the result field.
   assign sum_in = SUM_W'(rowsum_ff[0]) + SUM_W'(rowsum_ff[1]) + SUM_W'(rowsum_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s4_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_move) begin
         filtered_ff   <= sum_in[FILT_W-1:0];
         frame_last_ff <= s4_last_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.filtered   = filtered_ff;
   assign rsp_if.frame_last = frame_last_ff;

endmodule

FILE: rtl/kc3_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kc3_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kc3_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 1024,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/kc3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kc3_checker
// Port-level checks of the 3x3 convolution core, bound to the top level.
// ----------------------------------------------------------------------------
`include "kernel_convolution_3x3_core_macros.svh"

module kc3_checker import kc3_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input filtered_type rsp_filtered,
   input logic         rsp_frame_last
);

   // Count pixels taken in minus results handed out.
   logic [31:0] pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 32'(req_valid && req_ready)
                                  - 32'(rsp_valid && rsp_ready);
      end
   end

   `KC3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_filtered) && $stable(rsp_frame_last), "stalled result changed")

   `KC3_ASSERT_NOW(a_rsp_range, clock, reset, rsp_valid, (rsp_filtered >= -FILT_LIMIT) && (rsp_filtered <= FILT_LIMIT), "result outside kernel sum range")

   `KC3_ASSERT_NOW(a_rsp_cause, clock, reset, rsp_valid && rsp_ready, pending_ff != 32'd0, "result without an earlier pixel")

endmodule

bind kernel_convolution_3x3_core kc3_checker u_kc3_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_filtered   (rsp_if.filtered),
   .rsp_frame_last (rsp_if.frame_last)
);

FILE: sim/kernel_convolution_3x3_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_convolution_3x3_core_tb
// Self-checking bench for the 3x3 raster convolution core.
// ----------------------------------------------------------------------------
// Streams pixel frames through the core under several kernel and geometry
// settings and checks every filtered result against a line-buffered software
// model of the window. The run covers the reset configuration, clamped
// widths and heights, the largest and smallest kernel taps, frames that wrap
// without a start marker, geometry narrowed mid-frame, random back-pressure
// and one long receiver hold-off that fills the core and stalls its input.
// ----------------------------------------------------------------------------
module kernel_convolution_3x3_core_tb;
   import kc3_pkg::*;

   localparam int unsigned     HALF_PERIOD       = 6;
   localparam int unsigned     RESET_CYCLES      = 7;
   localparam int unsigned     SETTLE_CYCLES     = 12;
   localparam int unsigned     HOLDOFF_CYCLES    = 400;
   localparam int unsigned     SMALL_ITEM_TARGET = 1600;
   localparam longint unsigned RUN_LIMIT_NS      = 64'd12_000_000;

   // Index that decodes to no register; a write there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   localparam coef_type TAP_MIN  = 16'sh8000;
   localparam coef_type TAP_MAX  = 16'sh7FFF;
   localparam coef_type TAP_ZERO = 16'sh0000;

   localparam csr_index_type KERNEL_ROW_REGS [3] =
      '{CSR_COEF_ROW_TOP, CSR_COEF_ROW_MIDDLE, CSR_COEF_ROW_BOTTOM};

   // Traffic modes, picked by phase number: none, sender gaps, receiver
   // stalls, light gaps on both sides.
   localparam int unsigned SEND_IDLE_PCT [4] = '{0, 65, 0, 7};
   localparam int unsigned RSP_STALL_PCT [4] = '{0, 0, 65, 7};

   typedef struct packed {
      pixel_type pixel;
      logic      frame_start;
   } pixel_beat_type;

   typedef struct packed {
      filtered_type filtered;
      logic         frame_last;
   } conv_result_type;

   logic clock = 1'b0;
   logic reset;

   kc3_req_if req_ch ();
   kc3_rsp_if rsp_ch ();
   kc3_csr_if csr_ch ();

   kernel_convolution_3x3_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Pixels waiting to be offered, and filtered sums waiting to come out.
   pixel_beat_type  pixel_queue [$];
   conv_result_type pending_sums [$];

   int unsigned send_idle_pct    = 0;
   int unsigned rsp_stall_pct    = 0;
   int unsigned holdoff_requests = 0;
   int unsigned fail_count       = 0;
   bit          req_accepted     = 1'b0;

   // Shadow of the core: registers, line stores, window and raster position.
   // Line stores start as X, so any read of an unwritten entry shows up as
   // a mismatch instead of passing silently.
   logic [WIDTH_REG_W-1:0]  shadow_width;
   logic [HEIGHT_REG_W-1:0] shadow_height;
   coef_row_type            shadow_kernel [3];
   pixel_type               upper_line [KC3_MAX_WIDTH];
   pixel_type               lower_line [KC3_MAX_WIDTH];
   pixel_type               window [3][3];
   int unsigned             col_pos;
   int unsigned             row_pos;

   function automatic int unsigned clamp_dim(int unsigned value, int unsigned hi);
      if (value < MIN_DIM) return MIN_DIM;
      if (value > hi) return hi;
      return value;
   endfunction

   // Column 0 is the left tap, held in the top 16 bits of the row word.
   function automatic coef_type kernel_tap(coef_row_type row, int unsigned col);
      coef_row_type shifted;
      shifted = row >> (COEF_W * (2 - col));
      return coef_type'(shifted[COEF_W-1:0]);
   endfunction

   // Advance the shadow by one accepted pixel; queue a sum when the pixel
   // completes the window of an interior pixel.
   function automatic void convolve_pixel(pixel_type px, logic start);
      int unsigned       w;
      int unsigned       h;
      int unsigned       c;
      int unsigned       r;
      logic signed [39:0] acc;
      conv_result_type   sum;
      w = clamp_dim(shadow_width, KC3_MAX_WIDTH);
      h = clamp_dim(shadow_height, MAX_HEIGHT);
      if (start) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      for (int i = 0; i < 3; i++) begin
         window[i][0] = window[i][1];
         window[i][1] = window[i][2];
      end
      window[0][2] = upper_line[c];
      window[1][2] = lower_line[c];
      window[2][2] = px;
      upper_line[c] = lower_line[c];
      lower_line[c] = px;
      if (r >= 2 && c >= 2) begin
         acc = '0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               acc = acc + $signed({1'b0, window[i][j]}) * kernel_tap(shadow_kernel[i], j);
            end
         end
         sum.filtered   = acc[FILT_W-1:0];
         sum.frame_last = (r == h - 1) && (c == w - 1);
         pending_sums.push_back(sum);
      end
      // Wrap the column at the width, and the row at the height.
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   // Sample both channels at the rising edge: check results first, then
   // feed an accepted pixel to the shadow.
   always @(posedge clock) begin : result_monitor
      conv_result_type want;
      if (reset) begin
         col_pos = 0;
         row_pos = 0;
         foreach (window[i, j]) window[i][j] = '0;
         req_accepted = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_sums.size() == 0) begin
               $error("unexpected result: filtered %0d frame_last %0b",
                      rsp_ch.filtered, rsp_ch.frame_last);
               fail_count++;
            end else begin
               want = pending_sums.pop_front();
               if (rsp_ch.filtered !== want.filtered) begin
                  $error("filtered: expected %0d, actual %0d", want.filtered, rsp_ch.filtered);
                  fail_count++;
               end
               if (rsp_ch.frame_last !== want.frame_last) begin
                  $error("frame_last: expected %0b, actual %0b",
                         want.frame_last, rsp_ch.frame_last);
                  fail_count++;
               end
            end
         end
         req_accepted = req_ch.valid && req_ch.ready;
         if (req_accepted) convolve_pixel(req_ch.pixel, req_ch.frame_start);
      end
   end

   // Offer pixels at the falling edge. Hold a transaction until it is taken,
   // then either present the next one or idle with junk on the payload.
   always @(negedge clock) begin : pixel_driver
      pixel_beat_type beat;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_accepted) begin
         if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            beat = pixel_queue.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.pixel       <= beat.pixel;
            req_ch.frame_start <= beat.frame_start;
         end else begin
            req_ch.valid       <= 1'b0;
            req_ch.pixel       <= pixel_type'($urandom);
            req_ch.frame_start <= 1'($urandom);
         end
      end
   end

   // Drive result ready at the falling edge. A hold-off request drops ready
   // for a fixed stretch, counted here, regardless of the stall mode.
   int unsigned holdoff_seen = 0;
   int unsigned holdoff_left = 0;

   always @(negedge clock) begin : result_sink
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (holdoff_seen != holdoff_requests) begin
            holdoff_seen = holdoff_requests;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Fill the bits above a register's width with junk; the core drops them.
   function automatic logic [CSR_DATA_W-1:0] with_junk(int unsigned value, int unsigned bits);
      logic [CSR_DATA_W-1:0] word;
      word = {16'($urandom), $urandom};
      word = word >> bits;
      word = word << bits;
      return word | CSR_DATA_W'(value);
   endfunction

   // Bias taps toward the extremes and zero.
   function automatic coef_row_type rand_kernel_row();
      coef_row_type row;
      row = '0;
      for (int k = 0; k < 3; k++) begin
         row = row << COEF_W;
         case ($urandom_range(5))
            0:       row[COEF_W-1:0] = TAP_MIN;
            1:       row[COEF_W-1:0] = TAP_MAX;
            2:       row[COEF_W-1:0] = TAP_ZERO;
            default: row[COEF_W-1:0] = COEF_W'($urandom);
         endcase
      end
      return row;
   endfunction

   // One register write transaction; update the shadow once it is taken.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      case (idx)
         CSR_IMAGE_WIDTH:     shadow_width     = value[WIDTH_REG_W-1:0];
         CSR_IMAGE_HEIGHT:    shadow_height    = value[HEIGHT_REG_W-1:0];
         CSR_COEF_ROW_TOP:    shadow_kernel[0] = value[ROW_W-1:0];
         CSR_COEF_ROW_MIDDLE: shadow_kernel[1] = value[ROW_W-1:0];
         CSR_COEF_ROW_BOTTOM: shadow_kernel[2] = value[ROW_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Queue a run of pixels. Lead with a frame start if asked; scatter
   // stray frame starts at the given rate per thousand.
   task automatic queue_pixels(int unsigned count, bit lead, int unsigned noise_permille,
                               bit bright);
      pixel_beat_type beat;
      for (int unsigned k = 0; k < count; k++) begin
         if (bright) beat.pixel = 8'hFF;
         else begin
            case ($urandom_range(7))
               0:       beat.pixel = 8'h00;
               1:       beat.pixel = 8'hFF;
               default: beat.pixel = pixel_type'($urandom);
            endcase
         end
         beat.frame_start = (k == 0 && lead) || ($urandom_range(999) < noise_permille);
         pixel_queue.push_back(beat);
      end
   endtask

   // Wait until every pixel is taken and every sum has come out, then give
   // the pipeline time to flush pixels that produce nothing.
   task automatic settle();
      while (pixel_queue.size() != 0 || req_ch.valid || pending_sums.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_traffic(int unsigned phase);
      send_idle_pct = SEND_IDLE_PCT[phase % 4];
      rsp_stall_pct = RSP_STALL_PCT[phase % 4];
   endtask

   initial begin : stimulus
      int unsigned small_items;
      int unsigned last_width;
      int unsigned new_width;
      int unsigned new_height;
      int unsigned eff_w;
      int unsigned eff_h;
      int unsigned count;
      bit          lead;

      // Drive every input to a known value before the first edge.
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.pixel       = '0;
      req_ch.frame_start = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = '0;
      csr_ch.data        = '0;
      shadow_width       = WIDTH_RESET;
      shadow_height      = HEIGHT_RESET;
      shadow_kernel[0]   = COEF_TOP_RESET;
      shadow_kernel[1]   = COEF_MIDDLE_RESET;
      shadow_kernel[2]   = COEF_BOTTOM_RESET;
      small_items        = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Reset configuration: 640-wide rows through the identity kernel,
      // starting from the reset position without a frame start.
      set_traffic(0);
      queue_pixels(2 * 640 + 40, 1'b0, 0, 1'b0);
      last_width = 640;
      settle();

      // Smallest frame, widths and heights below range, most negative taps
      // on full-scale pixels: the most negative sum, marked last.
      set_traffic(1);
      write_register(CSR_IMAGE_WIDTH, with_junk(0, WIDTH_REG_W));
      write_register(CSR_IMAGE_HEIGHT, with_junk(1, HEIGHT_REG_W));
      for (int k = 0; k < 3; k++) write_register(KERNEL_ROW_REGS[k], {3{TAP_MIN}});
      write_register(CSR_SPARE_INDEX, {16'($urandom), $urandom});
      queue_pixels(9, 1'b1, 0, 1'b1);
      last_width = 3;
      settle();

      // Largest taps; the frame follows without a start marker, relying on
      // the wrap at the end of the previous frame.
      set_traffic(2);
      write_register(CSR_IMAGE_HEIGHT, with_junk(2, HEIGHT_REG_W));
      for (int k = 0; k < 3; k++) write_register(KERNEL_ROW_REGS[k], {3{TAP_MAX}});
      queue_pixels(9, 1'b0, 0, 1'b1);
      settle();

      // Random phases. Widening needs a fresh frame so that no unwritten
      // line-store entry is read; narrowing may continue the current frame,
      // which changes geometry mid-frame.
      for (int unsigned phase_no = 0;
           small_items < SMALL_ITEM_TARGET || phase_no < 10; phase_no++) begin
         set_traffic(phase_no);
         if (phase_no == 3) begin
            new_width  = 2047;   // clamps to the full line store
            new_height = 3;
         end else if (phase_no == 9) begin
            new_width  = 3;
            new_height = 8191;   // clamps to the tallest frame
         end else if (phase_no == 6) begin
            new_width  = 8;
            new_height = 8;
         end else begin
            new_width  = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            new_height = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
         end
         write_register(CSR_IMAGE_WIDTH, with_junk(new_width, WIDTH_REG_W));
         write_register(CSR_IMAGE_HEIGHT, with_junk(new_height, HEIGHT_REG_W));
         for (int k = 0; k < 3; k++)
            if (phase_no == 0 || $urandom_range(1))
               write_register(KERNEL_ROW_REGS[k], rand_kernel_row());
         eff_w = clamp_dim(new_width, KC3_MAX_WIDTH);
         eff_h = clamp_dim(new_height, MAX_HEIGHT);
         lead  = (eff_w > last_width) || $urandom_range(1);

         if (phase_no == 3) begin
            queue_pixels(3 * eff_w, 1'b1, 0, 1'b0);
         end else if (phase_no == 9) begin
            queue_pixels(30, 1'b1, 0, 1'b0);
         end else if (phase_no == 6) begin
            // Keep the sender busy and hold the receiver off, so results
            // back up and the core stalls its input.
            send_idle_pct = 0;
            rsp_stall_pct = 0;
            count = 3 * eff_w * eff_h;
            queue_pixels(count, lead, 0, 1'b0);
            holdoff_requests++;
            small_items += count;
         end else begin
            count = $urandom_range(1, 2) * eff_w * eff_h + $urandom_range(0, 2 * eff_w);
            queue_pixels(count, lead, 10, 1'b0);
            small_items += count;
         end
         last_width = eff_w;
         settle();
      end

      if (fail_count == 0) begin
         $display("kernel_convolution_3x3_core: match");
      end else begin
         $display("kernel_convolution_3x3_core: mismatch");
      end
      $finish;
   end

   // Give up on a hung run.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("kernel_convolution_3x3_core: mismatch");
      $finish;
   end

endmodule
